// ===== src/spn27_pkg.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// spn27_pkg
// Shared widths, function codes, stage record and round functions of the
// 27-bit SPN block cipher core.
// ---------------------------------------------------------------------------
package spn27_pkg;

   // round count and field widths
   localparam int ROUND_COUNT = 56;
   localparam int BLOCK_W     = 27;
   localparam int KEY_W       = 45;
   localparam int SEL_W       = 18;
   localparam int SLOT_W      = 6;
   localparam int FUNC_W      = 2;
   localparam int GROUP_COUNT = 9;
   localparam int PERM_SPAN   = 26;
   localparam int PERM_STRIDE = 3;

   // function codes
   localparam logic [FUNC_W-1:0] FUNC_LOAD    = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_ENCRYPT = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_DECRYPT = 2'd2;

   // swap selector codes
   localparam logic [1:0] SWAP_NONE  = 2'd0;
   localparam logic [1:0] SWAP_01    = 2'd1;
   localparam logic [1:0] SWAP_12    = 2'd2;
   localparam logic [1:0] SWAP_02    = 2'd3;

   // 3-bit S-box and its inverse
   localparam logic [2:0] SBOX_FWD [0:7] = '{3'd0, 3'd1, 3'd3, 3'd6, 3'd7, 3'd4, 3'd5, 3'd2};
   localparam logic [2:0] SBOX_INV [0:7] = '{3'd0, 3'd1, 3'd7, 3'd2, 3'd5, 3'd6, 3'd3, 3'd4};

   // one pipeline stage: valid travels with the block and the direction
   typedef struct packed {
      logic               valid;
      logic               dec;
      logic [BLOCK_W-1:0] blk;
   } stage_type;

   // string position p is bit BLOCK_W-1-p; the last position stays put
   function automatic logic [BLOCK_W-1:0] perm_fwd(input logic [BLOCK_W-1:0] x);
      logic [BLOCK_W-1:0] r;
      r = '0;
      for (int i = 0; i < PERM_SPAN; i++) begin
         r[BLOCK_W-1-((PERM_STRIDE*i) % PERM_SPAN)] = x[BLOCK_W-1-i];
      end
      r[0] = x[0];
      return r;
   endfunction

   function automatic logic [BLOCK_W-1:0] perm_inv(input logic [BLOCK_W-1:0] x);
      logic [BLOCK_W-1:0] r;
      r = '0;
      for (int i = 0; i < PERM_SPAN; i++) begin
         r[BLOCK_W-1-i] = x[BLOCK_W-1-((PERM_STRIDE*i) % PERM_SPAN)];
      end
      r[0] = x[0];
      return r;
   endfunction

   // keyed swaps inside each 3-bit group; each swap is its own inverse
   function automatic logic [BLOCK_W-1:0] keyed_swap(input logic [BLOCK_W-1:0] x,
                                                     input logic [SEL_W-1:0] sel);
      logic [BLOCK_W-1:0] r;
      logic [2:0]         c;
      logic [1:0]         s;
      r = '0;
      for (int g = 0; g < GROUP_COUNT; g++) begin
         c = x[BLOCK_W-1-3*g -: 3];
         s = sel[SEL_W-1-2*g -: 2];
         case (s)
            SWAP_NONE: r[BLOCK_W-1-3*g -: 3] = c;
            SWAP_01:   r[BLOCK_W-1-3*g -: 3] = {c[1], c[2], c[0]};
            SWAP_12:   r[BLOCK_W-1-3*g -: 3] = {c[2], c[0], c[1]};
            SWAP_02:   r[BLOCK_W-1-3*g -: 3] = {c[0], c[1], c[2]};
            default:   r[BLOCK_W-1-3*g -: 3] = c;
         endcase
      end
      return r;
   endfunction

   function automatic logic [BLOCK_W-1:0] sub_fwd(input logic [BLOCK_W-1:0] x);
      logic [BLOCK_W-1:0] r;
      r = '0;
      for (int g = 0; g < GROUP_COUNT; g++) begin
         r[BLOCK_W-1-3*g -: 3] = SBOX_FWD[x[BLOCK_W-1-3*g -: 3]];
      end
      return r;
   endfunction

   function automatic logic [BLOCK_W-1:0] sub_inv(input logic [BLOCK_W-1:0] x);
      logic [BLOCK_W-1:0] r;
      r = '0;
      for (int g = 0; g < GROUP_COUNT; g++) begin
         r[BLOCK_W-1-3*g -: 3] = SBOX_INV[x[BLOCK_W-1-3*g -: 3]];
      end
      return r;
   endfunction

endpackage
`default_nettype wire

// ===== src/spn27_stage.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// spn27_stage
// One registered round of the cipher pipeline; the direction bit picks the
// forward round or the inverse round.
// ---------------------------------------------------------------------------
module spn27_stage (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     advance,
   input  wire spn27_pkg::stage_type     stage_in,
   input  wire logic [spn27_pkg::KEY_W-1:0] key_enc,
   input  wire logic [spn27_pkg::KEY_W-1:0] key_dec,
   output spn27_pkg::stage_type          stage_ff
);
   import spn27_pkg::*;

   logic [BLOCK_W-1:0] enc_blk;
   logic [BLOCK_W-1:0] dec_blk;
   logic [BLOCK_W-1:0] blk_in;

   // forward round: xor, permute, swap, substitute
   always_comb begin
      enc_blk = stage_in.blk ^ key_enc[KEY_W-1:SEL_W];
      enc_blk = perm_fwd(enc_blk);
      enc_blk = keyed_swap(enc_blk, key_enc[SEL_W-1:0]);
      enc_blk = sub_fwd(enc_blk);
   end

   // inverse round: substitute, swap, permute, xor
   always_comb begin
      dec_blk = sub_inv(stage_in.blk);
      dec_blk = keyed_swap(dec_blk, key_dec[SEL_W-1:0]);
      dec_blk = perm_inv(dec_blk);
      dec_blk = dec_blk ^ key_dec[KEY_W-1:SEL_W];
   end

   assign blk_in = stage_in.dec ? dec_blk : enc_blk;

   // stage register; only valid is reset
   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff.valid <= 1'b0;
      end else if (advance) begin
         stage_ff.valid <= stage_in.valid;
         stage_ff.dec   <= stage_in.dec;
         stage_ff.blk   <= blk_in;
      end
   end

endmodule
`default_nettype wire

// ===== src/spn27_block_cipher_core.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// spn27_block_cipher_core
// 27-bit substitution-permutation block cipher, 56 rounds, one round per
// pipeline stage; key loads fill a register file of round keys.
// ---------------------------------------------------------------------------
//
//  channel | ports                                          | direction
//  --------+------------------------------------------------+----------
//  req     | req_valid/ready, func, data_block, key_slot,   | in
//          | round_key_value                                |
//  rsp     | rsp_valid/ready, result_block                  | out
//
//  Encrypt and decrypt beats enter one per cycle while the output is not
//  stalled; the entry register loads on the accepting edge, then each round
//  stage in turn carries the block on to the output register.
//  A key-load beat is held off until the round pipeline has drained, so every
//  block in flight sees the keys present when it entered.
//  A stalled result freezes the whole pipeline; nothing is dropped or redone.
//  Reset clears the stage valid bits only; round keys are undefined until
//  loaded. Function code 3 and key slots past the last round are accepted
//  and discarded.
//
module spn27_block_cipher_core (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output logic                                    req_ready,
   input  wire logic [spn27_pkg::FUNC_W-1:0]       req_func,
   input  wire logic [spn27_pkg::BLOCK_W-1:0]      req_data_block,
   input  wire logic [spn27_pkg::SLOT_W-1:0]       req_key_slot,
   input  wire logic [spn27_pkg::KEY_W-1:0]        req_round_key_value,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_ready,
   output logic [spn27_pkg::BLOCK_W-1:0]           rsp_result_block
);
   import spn27_pkg::*;

   stage_type              pipe [0:ROUND_COUNT];
   stage_type              entry_in;
   logic [KEY_W-1:0]       key_ff [0:ROUND_COUNT-1];
   logic [ROUND_COUNT:0]   busy_vec;
   logic                   advance;
   logic                   req_fire;
   logic                   key_we;
   logic                   is_block;

   // pipeline moves as one unless the last stage holds an untaken result
   assign advance  = !pipe[ROUND_COUNT].valid || rsp_ready;
   assign req_fire = req_valid && req_ready;
   assign is_block = (req_func == FUNC_ENCRYPT) || (req_func == FUNC_DECRYPT);
   assign key_we   = req_fire && (req_func == FUNC_LOAD);

   // occupancy of every stage
   always_comb begin
      for (int k = 0; k <= ROUND_COUNT; k++) begin
         busy_vec[k] = pipe[k].valid;
      end
   end

   // key loads wait for an empty pipeline
   assign req_ready = advance && ((req_func != FUNC_LOAD) || !(|busy_vec));

   // round key register file, one write port, fixed read per stage
   for (genvar k = 0; k < ROUND_COUNT; k++) begin : g_key
      always_ff @(posedge clock) begin
         if (key_we && (req_key_slot == SLOT_W'(k))) begin
            key_ff[k] <= req_round_key_value;
         end
      end
   end

   // entry register
   always_comb begin
      entry_in.valid = req_fire && is_block;
      entry_in.dec   = (req_func == FUNC_DECRYPT);
      entry_in.blk   = req_data_block;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pipe[0].valid <= 1'b0;
      end else if (advance) begin
         pipe[0] <= entry_in;
      end
   end

   // one round per stage; decrypt walks the keys from the top down
   for (genvar j = 0; j < ROUND_COUNT; j++) begin : g_round
      spn27_stage u_stage (
         .clock    (clock),
         .reset    (reset),
         .advance  (advance),
         .stage_in (pipe[j]),
         .key_enc  (key_ff[j]),
         .key_dec  (key_ff[ROUND_COUNT-1-j]),
         .stage_ff (pipe[j+1])
      );
   end

   // last stage is the output register
   assign rsp_valid        = pipe[ROUND_COUNT].valid;
   assign rsp_result_block = pipe[ROUND_COUNT].blk;

   // key file never changes under a block in flight
   a_key_quiet: assert property (@(posedge clock) disable iff (reset)
      key_we |-> !(|busy_vec))
      else $error("round key written while blocks in flight");

   // a stalled result freezes every stage's occupancy
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> $stable(busy_vec))
      else $error("pipeline moved during output stall");

   // an accepted block beat lands in the entry register
   a_entry: assert property (@(posedge clock) disable iff (reset)
      (req_fire && is_block) |=> pipe[0].valid)
      else $error("accepted block missing from entry stage");

   // non-block beats never create work
   a_no_phantom: assert property (@(posedge clock) disable iff (reset)
      (advance && !(req_fire && is_block)) |=> !pipe[0].valid)
      else $error("entry stage valid without a block beat");

endmodule
`default_nettype wire
